[src/vsfd_pkg.sv]
// Shared types, constants and the field decode function of the status frame decoder.
package vsfd_pkg;

	localparam int EXT_LEN = 47;
	localparam int OLD_LEN = 26;
	localparam int NEW_LEN = 27;
	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [5:0] LAST_ID_BASE = 6'd19;
	localparam logic [5:0] LAST_ID_EXT  = 6'd36;
	localparam logic [1:0] FMT_OLD = 2'd0;
	localparam logic [1:0] FMT_NEW = 2'd1;

	typedef enum logic [1:0] {
		LEN_OLD = 2'd0,
		LEN_NEW = 2'd1,
		LEN_EXT = 2'd2
	} len_code_t;

	typedef logic [EXT_LEN-1:0][7:0] frame_bytes_t;

	// One captured frame as it travels from the front to the back.
	typedef struct packed {
		frame_bytes_t bytes;
		len_code_t    len;
	} frame_t;

	typedef struct packed {
		logic [16:0] value;
		logic        invalid;
	} field_t;

	function automatic logic [16:0] sign_mag(input logic [15:0] mag, input logic neg);
		logic [16:0] m;
		m = {1'b0, mag};
		return neg ? (17'd0 - m) : m;
	endfunction

	function automatic logic [16:0] plus_minus_one(input logic neg);
		return neg ? 17'h1FFFF : 17'd1;
	endfunction

	// Decode one field of a frame; qualified fields read zero when flagged invalid.
	function automatic field_t decode_field(input frame_t f, input logic [5:0] id);
		field_t r;
		frame_bytes_t d;
		logic [9:0] imp;
		d = f.bytes;
		imp = '0;
		r.value = '0;
		r.invalid = 1'b0;
		case (id)
			6'd0: r.value = {16'd0, d[0][4]};
			6'd1: r.value = {16'd0, d[0][2]};
			6'd2: begin
				r.value = {1'b0, d[2], d[1]};
				r.invalid = (d[2] == 8'hFF);
			end
			6'd3: r.value = {16'd0, d[2] == 8'hFF};
			6'd4: begin
				r.value = {9'd0, d[3]};
				r.invalid = (d[3] == 8'hFF);
			end
			6'd5: r.value = {16'd0, d[3] == 8'hFF};
			6'd6: r.value = sign_mag({1'b0, d[5][6:0], d[4]}, d[5][7]);
			6'd7: r.value = sign_mag({1'b0, d[7][6:0], d[6]}, d[7][7]);
			6'd8: r.value = {13'd0, d[9][3:0]};
			6'd9: r.value = {13'd0, d[9][7:4]};
			6'd10: r.value = sign_mag({1'b0, d[11], d[10][7:1]}, d[10][0]);
			6'd11: r.value = sign_mag({1'b0, d[13], d[12][7:1]}, d[12][0]);
			6'd12: r.value = sign_mag({1'b0, d[15], d[14][7:1]}, d[14][0]);
			6'd13: r.value = sign_mag({1'b0, d[17], d[16][7:1]}, d[16][0]);
			6'd14: r.value = {5'd0, d[19][3:0], d[18]};
			6'd15: begin
				r.value = {9'd0, d[20]} - 17'd127;
				r.invalid = (d[20] >= 8'hFE);
			end
			6'd16: begin
				r.value = {9'd0, d[21]} - 17'd127;
				r.invalid = (d[21] >= 8'hFE);
			end
			6'd17: begin
				r.value = {9'd0, d[22]} - 17'd127;
				r.invalid = (d[22] >= 8'hFE);
			end
			6'd18: begin
				r.value = {9'd0, d[23]} - 17'd127;
				r.invalid = (d[23] >= 8'hFE);
			end
			6'd19: r.value = {16'd0, (f.len != LEN_OLD) & d[24][6]};
			6'd20: r.value = {9'd0, d[25]};
			6'd21: r.value = {1'b0, d[27], d[26]};
			6'd22: r.value = {1'b0, d[29], d[28]};
			6'd23: begin
				r.invalid = d[31][6];
				r.value = r.invalid ? 17'd0 : sign_mag({2'b0, d[31][5:0], d[30]}, d[31][7]);
			end
			6'd24: r.value = {16'd0, d[32][0]};
			6'd25, 6'd27, 6'd29, 6'd31: begin
				case (id)
					6'd25: begin
						imp = {d[35][1:0], d[34]};
						r.invalid = d[33][4];
					end
					6'd27: begin
						imp = {d[36][3:0], d[35][7:2]};
						r.invalid = d[33][5];
					end
					6'd29: begin
						imp = {d[37][5:0], d[36][7:4]};
						r.invalid = d[33][6];
					end
					default: begin
						imp = {d[38], d[37][7:6]};
						r.invalid = d[33][7];
					end
				endcase
				r.value = r.invalid ? 17'd0 : {7'd0, imp};
			end
			6'd26: begin
				r.invalid = d[39][0];
				r.value = r.invalid ? 17'd0 : plus_minus_one(d[39][4]);
			end
			6'd28: begin
				r.invalid = d[39][1];
				r.value = r.invalid ? 17'd0 : plus_minus_one(d[39][5]);
			end
			6'd30: begin
				r.invalid = d[39][2];
				r.value = r.invalid ? 17'd0 : plus_minus_one(d[39][6]);
			end
			6'd32: begin
				r.invalid = d[39][3];
				r.value = r.invalid ? 17'd0 : plus_minus_one(d[39][7]);
			end
			6'd33: r.value = plus_minus_one(!d[40][7]);
			6'd34: begin
				r.invalid = d[42][5];
				r.value = r.invalid ? 17'd0 : sign_mag({4'd0, d[42][3:0], d[41]}, d[42][4]);
			end
			6'd35: begin
				r.invalid = d[44][3];
				r.value = r.invalid ? 17'd0 : sign_mag({6'd0, d[44][1:0], d[43]}, d[44][2]);
			end
			6'd36: r.value = {13'd0, d[44][7:4]};
			default: r.value = '0;
		endcase
		return r;
	endfunction

endpackage

[src/vsfd_front.sv]
// Front part: byte window, sync detection and frame capture.
module vsfd_front #(
	parameter int MAX_FRAME_BYTES = 47
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vsfd_pkg::len_code_t len,
	input  logic               take,
	input  logic [7:0]         rx_byte,
	output logic               push,
	output vsfd_pkg::frame_t   frame
);
	import vsfd_pkg::*;

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

	logic [7:0]    sr_q [MAX_FRAME_BYTES-1];
	logic [CW-1:0] cnt_q;
	logic [7:0]    nw [MAX_FRAME_BYTES];
	logic [6:0]    len7;
	logic [6:0]    keep7;
	logic          hit;

	// Window length of the active format.
	always_comb begin
		case (len)
			LEN_OLD: len7 = 7'(OLD_LEN);
			LEN_EXT: len7 = 7'(EXT_LEN);
			default: len7 = 7'(NEW_LEN);
		endcase
	end

	// Held bytes beyond the newest length-1 are dropped before the new byte.
	assign keep7 = (7'(cnt_q) > len7 - 7'd1) ? (len7 - 7'd1) : 7'(cnt_q);
	assign hit = (keep7 + 7'd1 == len7) && (sr_q[0] == SYNC_FIRST) &&
		(rx_byte == SYNC_SECOND);
	assign push = take && hit;

	// Window after this byte, newest first.
	always_comb begin
		nw[0] = rx_byte;
		for (int k = 1; k < MAX_FRAME_BYTES; k++) begin
			nw[k] = sr_q[k-1];
		end
	end

	// Frame byte i is the window byte that is len-1-i places back.
	always_comb begin
		frame.len = len;
		frame.bytes = '0;
		for (int i = 0; i < EXT_LEN; i++) begin
			case (len)
				LEN_OLD: if (i < OLD_LEN) frame.bytes[i] = nw[OLD_LEN-1-i];
				LEN_EXT: if (MAX_FRAME_BYTES >= EXT_LEN)
					frame.bytes[i] = nw[(EXT_LEN-1-i) % MAX_FRAME_BYTES];
				default: if (i < NEW_LEN) frame.bytes[i] = nw[NEW_LEN-1-i];
			endcase
		end
	end

	// Shift line of received bytes; only length-1 bytes need to be held.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < MAX_FRAME_BYTES - 1; k++) begin
				sr_q[k] <= nw[k];
			end
		end
	end

	// Fill count; a decoded frame empties the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= hit ? '0 : CW'(keep7 + 7'd1);
		end
	end

endmodule

[src/vsfd_fifo.sv]
// Two-entry frame queue between the front and the back.
module vsfd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vsfd_pkg::frame_t push_frame,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output vsfd_pkg::frame_t head
);
	import vsfd_pkg::*;

	frame_t     mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q[1];
	assign not_empty = (cnt_q != 2'd0);
	assign head = mem_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_frame;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[src/vsfd_back.sv]
// Back part: walks the fields of the head frame into the output register.
module vsfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               have_frame,
	input  vsfd_pkg::frame_t   head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         field_id,
	output logic signed [16:0] field_value,
	output logic               field_invalid,
	output logic               last_field
);
	import vsfd_pkg::*;

	logic [5:0] idx_q;
	logic       load;
	logic       is_last;
	field_t     fld;

	assign load = have_frame && (!out_valid || !out_stall);
	assign is_last = (head.len == LEN_EXT) ? (idx_q == LAST_ID_EXT) : (idx_q == LAST_ID_BASE);
	assign pop = load && is_last;
	assign fld = decode_field(head, idx_q);

	// Field counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 6'd0 : idx_q + 6'd1;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			field_id <= idx_q;
			field_value <= fld.value;
			field_invalid <= fld.invalid;
			last_field <= is_last;
		end
	end

endmodule

[src/vehicle_status_frame_decoder.sv]
// Top level of the vehicle status frame decoder.
// Input channel: in_valid/in_stall carry one received byte (rx_byte) per transfer.
// Output channel: out_valid/out_stall carry one decoded status field per transfer:
// field_id, field_value (signed raw units), field_invalid and last_field on the
// final field of a frame (20 fields, or 37 in the extended format).
// The user must write frame_format with frame_format_we only while the block is
// idle; the block does not enforce it. It takes one byte every cycle while in_stall
// is low. A byte that completes a frame with the sync pair enters a two-entry frame
// queue; the back part walks the frame's fields out, one per cycle unless stalled.
// Frames are at least 26 bytes apart, so the field walk keeps pace with input.
// A receiver stall holds the output register; the queue absorbs frames, and
// in_stall rises only while the queue holds two frames.
// Reset empties the window and queue and sets frame_format to the 27-byte format.
module vehicle_status_frame_decoder #(
	parameter int MAX_FRAME_BYTES = 47
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_format_we,
	input  logic [1:0]         frame_format,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         field_id,
	output logic signed [16:0] field_value,
	output logic               field_invalid,
	output logic               last_field
);
	import vsfd_pkg::*;

	logic [1:0] fmt_q;
	len_code_t  len;
	logic       take;
	logic       push;
	logic       pop;
	logic       full;
	logic       not_empty;
	frame_t     cap;
	frame_t     head;

	// Format register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_NEW;
		end else if (frame_format_we) begin
			fmt_q <= frame_format;
		end
	end

	// Format to frame length; extended needs a window of full size.
	always_comb begin
		if (fmt_q == FMT_OLD) len = LEN_OLD;
		else if (fmt_q != FMT_NEW && MAX_FRAME_BYTES >= EXT_LEN) len = LEN_EXT;
		else len = LEN_NEW;
	end

	assign in_stall = full;
	assign take = in_valid && !full;

	vsfd_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .len(len), .take(take), .rx_byte(rx_byte),
		.push(push), .frame(cap)
	);

	vsfd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_frame(cap), .pop(pop),
		.full(full), .not_empty(not_empty), .head(head)
	);

	vsfd_back u_back (
		.clk(clk), .arst_n(arst_n), .have_frame(not_empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .field_id(field_id),
		.field_value(field_value), .field_invalid(field_invalid), .last_field(last_field)
	);

`ifndef SYNTHESIS
	// The last field is always field 19 or field 36.
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_field |-> field_id == LAST_ID_BASE || field_id == LAST_ID_EXT)
		else $error("last field with wrong id");

	// Fields of one frame follow without gaps.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_field |=> out_valid && field_id == $past(field_id) + 6'd1)
		else $error("field sequence broken");

	// A new frame starts at field zero.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_field ##1 out_valid && !$past(out_valid && out_stall)
		|-> field_id == 6'd0)
		else $error("frame did not start at field zero");

	// The queue never overflows or underflows.
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !not_empty))
		else $error("frame queue misuse");
`endif

endmodule

[bench/vsfd_checker.sv]
// Checker for the status frame decoder: watches both channels, predicts the fields and compares.
module vsfd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_format_we,
	input  logic [1:0]         frame_format,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [5:0]         field_id,
	input  logic signed [16:0] field_value,
	input  logic               field_invalid,
	input  logic               last_field,
	output int                 fail_count,
	output int                 pending_fields,
	output int                 frames_decoded
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [5:0]  id;
		logic [16:0] value;
		logic        invalid;
		logic        last;
	} status_field_t;

	status_field_t expected_fields[$];
	logic [7:0] held_bytes[vsfd_pkg::EXT_LEN];
	int unsigned held_count;
	logic [1:0] format_reg;

	function automatic int unsigned window_len(input logic [1:0] fmt);
		if (fmt == vsfd_pkg::FMT_OLD) return vsfd_pkg::OLD_LEN;
		if (fmt == vsfd_pkg::FMT_NEW) return vsfd_pkg::NEW_LEN;
		return vsfd_pkg::EXT_LEN;
	endfunction

	function automatic logic [16:0] signed_mag(input int unsigned mag, input logic neg);
		return neg ? 17'(-int'(mag)) : 17'(mag);
	endfunction

	task automatic push_field(input int unsigned id, input logic [16:0] v, input logic inv,
			input logic qualified);
		status_field_t f;
		f.id = 6'(id);
		f.value = (qualified && inv) ? 17'd0 : v;
		f.invalid = inv;
		f.last = 1'b0;
		expected_fields.push_back(f);
	endtask

	// Unpack one complete frame into its field list.
	task automatic decode_frame(input logic [7:0] d[vsfd_pkg::EXT_LEN], input int unsigned len);
		int unsigned imp[4];
		logic q;
		push_field(0, 17'(d[0][4]), 0, 0);
		push_field(1, 17'(d[0][2]), 0, 0);
		q = (d[2] == 8'hFF);
		push_field(2, {1'b0, d[2], d[1]}, q, 0);
		push_field(3, 17'(q), 0, 0);
		q = (d[3] == 8'hFF);
		push_field(4, 17'(d[3]), q, 0);
		push_field(5, 17'(q), 0, 0);
		push_field(6, signed_mag({d[5][6:0], d[4]}, d[5][7]), 0, 0);
		push_field(7, signed_mag({d[7][6:0], d[6]}, d[7][7]), 0, 0);
		push_field(8, 17'(d[9][3:0]), 0, 0);
		push_field(9, 17'(d[9][7:4]), 0, 0);
		for (int i = 0; i < 4; i++)
			push_field(10 + i, signed_mag({d[11 + 2 * i], d[10 + 2 * i][7:1]},
				d[10 + 2 * i][0]), 0, 0);
		push_field(14, {5'd0, d[19][3:0], d[18]}, 0, 0);
		for (int i = 0; i < 4; i++)
			push_field(15 + i, 17'(int'(d[20 + i]) - 127), d[20 + i] >= 8'hFE, 0);
		push_field(19, (len == vsfd_pkg::OLD_LEN) ? 17'd0 : 17'(d[24][6]), 0, 0);
		if (len == vsfd_pkg::EXT_LEN) begin
			push_field(20, 17'(d[25]), 0, 0);
			push_field(21, {1'b0, d[27], d[26]}, 0, 0);
			push_field(22, {1'b0, d[29], d[28]}, 0, 0);
			push_field(23, signed_mag({d[31][5:0], d[30]}, d[31][7]), d[31][6], 1);
			push_field(24, 17'(d[32][0]), 0, 0);
			imp[0] = {d[35][1:0], d[34]};
			imp[1] = {d[36][3:0], d[35][7:2]};
			imp[2] = {d[37][5:0], d[36][7:4]};
			imp[3] = {d[38], d[37][7:6]};
			for (int i = 0; i < 4; i++) begin
				push_field(25 + 2 * i, 17'(imp[i]), d[33][4 + i], 1);
				push_field(26 + 2 * i, d[39][4 + i] ? 17'h1FFFF : 17'd1, d[39][i], 1);
			end
			push_field(33, d[40][7] ? 17'd1 : 17'h1FFFF, 0, 0);
			push_field(34, signed_mag({d[42][3:0], d[41]}, d[42][4]), d[42][5], 1);
			push_field(35, signed_mag({d[44][1:0], d[43]}, d[44][2]), d[44][3], 1);
			push_field(36, 17'(d[44][7:4]), 0, 0);
		end
		expected_fields[$].last = 1'b1;
	endtask

	// Slide one byte into the window and decode when a synced frame is complete.
	task automatic take_byte(input logic [7:0] b);
		int unsigned len;
		int unsigned keep;
		int unsigned drop;
		logic [7:0] frame[vsfd_pkg::EXT_LEN];
		len = window_len(format_reg);
		keep = held_count;
		if (keep > len - 1) begin
			drop = keep - (len - 1);
			for (int i = 0; i < len - 1; i++) held_bytes[i] = held_bytes[i + drop];
			keep = len - 1;
		end
		held_bytes[keep] = b;
		held_count = keep + 1;
		if (held_count == len && held_bytes[len - 2] == vsfd_pkg::SYNC_FIRST &&
				held_bytes[len - 1] == vsfd_pkg::SYNC_SECOND) begin
			for (int i = 0; i < vsfd_pkg::EXT_LEN; i++) begin
				frame[i] = (i < len) ? held_bytes[i] : 8'h00;
				held_bytes[i] = 8'h00;
			end
			held_count = 0;
			frames_decoded++;
			decode_frame(frame, len);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	// Compare each output transfer with the oldest expected field.
	task automatic check_field();
		status_field_t e;
		if (expected_fields.size() == 0) begin
			report_mismatch($sformatf("unexpected field id %0d", field_id));
			return;
		end
		e = expected_fields.pop_front();
		if (field_id !== e.id)
			report_mismatch($sformatf("field_id %0d, want %0d", field_id, e.id));
		if (field_value !== e.value)
			report_mismatch($sformatf("id %0d value %0d, want %0d", e.id, field_value,
				$signed(e.value)));
		if (field_invalid !== e.invalid)
			report_mismatch($sformatf("id %0d invalid %0b, want %0b", e.id, field_invalid,
				e.invalid));
		if (last_field !== e.last)
			report_mismatch($sformatf("id %0d last %0b, want %0b", e.id, last_field, e.last));
	endtask

	// Track configuration and both channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_fields.delete();
			for (int i = 0; i < vsfd_pkg::EXT_LEN; i++) held_bytes[i] = 8'h00;
			held_count = 0;
			format_reg = vsfd_pkg::FMT_NEW;
			fail_count = 0;
			frames_decoded = 0;
		end else begin
			if (out_valid && !out_stall) check_field();
			if (in_valid && !in_stall) take_byte(rx_byte);
			if (frame_format_we) format_reg = frame_format;
		end
		pending_fields = expected_fields.size();
	end
endmodule

[bench/tb.sv]
// Top of the status frame decoder testbench: clock, reset, stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               frame_format_we = 1'b0;
	logic [1:0]         frame_format = 2'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [5:0]         field_id;
	logic signed [16:0] field_value;
	logic               field_invalid;
	logic               last_field;
	int                 fail_count;
	int                 pending_fields;
	int                 frames_decoded;
	int                 bytes_sent = 0;
	int                 cycle_count = 0;
	int                 stall_mode = 0;
	logic [1:0]         current_format = 2'd1;

	vehicle_status_frame_decoder dut (.*);

	vsfd_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver stall pattern: a mode that changes now and then.
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// Send one byte, sometimes after a random gap, and wait for its transfer.
	// Valid stays high between bytes of a burst; here it drops only for a gap.
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Drop valid and wait until every predicted field has been transferred.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		wait (pending_fields == 0);
	endtask

	function automatic int unsigned frame_len_of(input logic [1:0] fmt);
		if (fmt == vsfd_pkg::FMT_OLD) return vsfd_pkg::OLD_LEN;
		if (fmt == vsfd_pkg::FMT_NEW) return vsfd_pkg::NEW_LEN;
		return vsfd_pkg::EXT_LEN;
	endfunction

	// A full frame: body bytes from a pattern, then the sync pair.
	task automatic send_frame(input int kind);
		int unsigned len;
		logic [7:0] b;
		len = frame_len_of(current_format);
		for (int i = 0; i < len - 2; i++) begin
			case (kind)
				0: b = 8'h00;
				1: b = 8'hFF;
				2: b = (i % 2) ? 8'hFE : 8'h7F;
				default: b = 8'($urandom);
			endcase
			send_byte(b);
		end
		send_byte(vsfd_pkg::SYNC_FIRST);
		send_byte(vsfd_pkg::SYNC_SECOND);
	endtask

	// Change the format only once the block has drained.
	task automatic set_format(input logic [1:0] fmt);
		drain();
		repeat (6) @(posedge clk);
		frame_format_we <= 1'b1;
		frame_format <= fmt;
		@(posedge clk);
		frame_format_we <= 1'b0;
		current_format = fmt;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset format with alternating sentinel bytes.
		send_frame(2);
		// Extended format with random bytes, then noise and an early sync pair.
		set_format(2'd2);
		send_frame(3);
		repeat (3) send_byte(8'($urandom));
		send_byte(vsfd_pkg::SYNC_FIRST);
		send_byte(vsfd_pkg::SYNC_SECOND);
		// Format code three on top of held bytes, so the window must slide.
		set_format(2'd3);
		send_frame(1);
		// Format change while the window holds more than the new length allows.
		repeat (30) send_byte(8'($urandom));
		set_format(2'd0);
		send_frame(3);

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes over all four format codes; %0d frames decoded.",
			bytes_sent, frames_decoded);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
